[src/tcah_pkg.sv]
// Shared types and constants for the tilt-compensated attitude and heading core.
package tcah_pkg;

    localparam int CordicW = 48;
    localparam int AtanMax = 24;
    localparam int ANGLE_FRAC_BITS = 8;

    typedef logic signed [CordicW-1:0] cval_t;

    localparam logic signed [31:0] DEG90_Q16 = 32'sd5898240;
    localparam logic signed [31:0] DEG180_Q16 = 32'sd11796480;
    localparam logic signed [31:0] DEG360_Q16 = 32'sd23592960;
    localparam logic [29:0] CORDIC_K_Q30 = 30'd652032875;

    function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
        logic signed [31:0] r;
        begin
            case (i)
                5'd0: r = 32'sd2949120;
                5'd1: r = 32'sd1740967;
                5'd2: r = 32'sd919879;
                5'd3: r = 32'sd466945;
                5'd4: r = 32'sd234379;
                5'd5: r = 32'sd117304;
                5'd6: r = 32'sd58666;
                5'd7: r = 32'sd29335;
                5'd8: r = 32'sd14668;
                5'd9: r = 32'sd7334;
                5'd10: r = 32'sd3667;
                5'd11: r = 32'sd1833;
                5'd12: r = 32'sd917;
                5'd13: r = 32'sd458;
                5'd14: r = 32'sd229;
                5'd15: r = 32'sd115;
                5'd16: r = 32'sd57;
                5'd17: r = 32'sd29;
                5'd18: r = 32'sd14;
                5'd19: r = 32'sd7;
                5'd20: r = 32'sd4;
                5'd21: r = 32'sd2;
                5'd22: r = 32'sd1;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

[src/tilt_compensated_attitude_heading_core.sv]
// Five CORDIC passes (steps capped at 24), two dividers and multiplies share one unit;
// the seeding sample skips the dividers and the blend, and a zero atan vector skips the
// CORDIC iterations.
// One input transfer is processed at a time; in_stall is high
// until the result is loaded into the output register, which holds it while stalled.
// Reset clears the angles, the seed flag, the sequencer and restores the register defaults.
module tilt_compensated_attitude_heading_core
    import tcah_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] mag_x,
    input  logic signed [15:0] mag_y,
    input  logic signed [15:0] mag_z,
    input  logic        [15:0] sample_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [16:0] pitch_deg,
    output logic signed [16:0] roll_deg,
    output logic        [16:0] heading_deg
);

    localparam int NSTEPS = (CORDIC_STEPS > AtanMax) ? AtanMax : CORDIC_STEPS;
    localparam logic [4:0] LAST_STEP = 5'(NSTEPS - 1);
    localparam int SH = 16 - ANGLE_FRAC_BITS;
    localparam int MAGW = 32 + ANGLE_FRAC_BITS;
    localparam logic [5:0] LAST_DIV = 6'(MAGW);
    localparam logic signed [47:0] ANG_MAX = 48'sd180 <<< ANGLE_FRAC_BITS;
    localparam logic signed [47:0] ANG_360 = 48'sd360 <<< ANGLE_FRAC_BITS;
    localparam logic signed [47:0] HALF_LSB = 48'sd1 <<< (SH - 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_AT_PRE = 5'd1;
    localparam logic [4:0] S_AT_IT = 5'd2;
    localparam logic [4:0] S_AT_END = 5'd3;
    localparam logic [4:0] S_DEN = 5'd4;
    localparam logic [4:0] S_NUM = 5'd5;
    localparam logic [4:0] S_DIV = 5'd6;
    localparam logic [4:0] S_BL1 = 5'd7;
    localparam logic [4:0] S_BL2 = 5'd8;
    localparam logic [4:0] S_BL3 = 5'd9;
    localparam logic [4:0] S_SC_PRE = 5'd10;
    localparam logic [4:0] S_SC_IT = 5'd11;
    localparam logic [4:0] S_SC_END = 5'd12;
    localparam logic [4:0] S_M1 = 5'd13;
    localparam logic [4:0] S_M2 = 5'd14;
    localparam logic [4:0] S_M3 = 5'd15;
    localparam logic [4:0] S_M4 = 5'd16;
    localparam logic [4:0] S_M5 = 5'd17;
    localparam logic [4:0] S_M6 = 5'd18;
    localparam logic [4:0] S_M7 = 5'd19;
    localparam logic [4:0] S_M8 = 5'd20;
    localparam logic [4:0] S_OUT = 5'd21;

    // phase: 0 pitch atan, 1 roll atan, 2 heading atan; sc axis 0 pitch, 1 roll
    logic [4:0]  state_reg;
    logic [1:0]  phase_reg;
    logic        axis_reg;
    logic [4:0]  step_reg;
    logic [16:0] alpha_reg;
    logic [15:0] lsb_reg;
    logic        seeded_reg;
    logic signed [16:0] pitch_reg, roll_reg;
    logic signed [16:0] pitch_o_reg, roll_o_reg;
    logic signed [16:0] pa_reg, ra_reg;
    logic [16:0] head_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic signed [15:0] mx_reg, my_reg, mz_reg;
    logic [15:0] ms_reg;
    cval_t x_reg, y_reg, z_reg;
    logic neg_reg;
    logic signed [16:0] sp_reg, cp_reg, sr_reg, cr_reg;
    cval_t xh_reg, yh_reg, acc_reg, tmp_reg;
    logic [MAGW-1:0] quo_reg;
    logic [31:0] rem_reg;
    logic [MAGW-1:0] mag_reg;
    logic [25:0] den_reg;
    logic        nneg_reg;
    logic [5:0]  dcnt_reg;
    logic        busy_reg;
    logic        ovalid_reg;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    cval_t xs, ys, x_step, y_step, z_step;
    logic signed [31:0] at;
    cval_t q16_in;
    cval_t q16_out;
    logic [32:0] rem_try;
    logic        rnd_up;
    logic [MAGW-1:0] delta_mag;
    logic        out_free;

    assign mul_p = mul_a * mul_b;
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign at = atan_q16(step_reg);
    assign q16_out = (q16_in + HALF_LSB) >>> SH;
    assign rem_try = {rem_reg, mag_reg[MAGW-1]} - {7'd0, den_reg};
    assign rnd_up = {1'b0, rem_reg, 1'b0} >= {8'd0, den_reg};
    assign delta_mag = quo_reg + {{(MAGW-1){1'b0}}, rnd_up};
    assign out_free = !ovalid_reg || !out_stall;

    function automatic logic signed [16:0] sat17(input cval_t v);
        begin
            if (v > ANG_MAX) return 17'(ANG_MAX);
            if (v < -ANG_MAX) return 17'(-ANG_MAX);
            return 17'(v);
        end
    endfunction

    always_comb
    begin
        x_step = x_reg;
        y_step = y_reg;
        z_step = z_reg;
        if (state_reg == S_AT_IT) begin
            if (!y_reg[CordicW-1]) begin
                x_step = x_reg + ys; y_step = y_reg - xs; z_step = z_reg + 48'(at);
            end else begin
                x_step = x_reg - ys; y_step = y_reg + xs; z_step = z_reg - 48'(at);
            end
        end else begin
            if (!z_reg[CordicW-1]) begin
                x_step = x_reg - ys; y_step = y_reg + xs; z_step = z_reg - 48'(at);
            end else begin
                x_step = x_reg + ys; y_step = y_reg - xs; z_step = z_reg + 48'(at);
            end
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        q16_in = z_reg;
        case (state_reg)
            S_DEN: begin mul_a = 34'(lsb_reg == 16'd0 ? 16'd1 : lsb_reg); mul_b = 34'sd1000; end
            S_NUM: begin
                mul_a = 34'(axis_reg ? gy_reg : gx_reg);
                mul_b = $signed({18'd0, ms_reg});
            end
            S_BL1: begin
                mul_a = $signed({17'd0, alpha_reg});
                mul_b = 34'(tmp_reg);
            end
            S_BL2: begin
                mul_a = $signed({17'd0, 17'(18'h10000 - {1'b0, alpha_reg})});
                mul_b = 34'(axis_reg ? ra_reg : pa_reg);
            end
            S_M1: begin mul_a = 34'(mx_reg); mul_b = 34'(cp_reg); end
            S_M2: begin mul_a = 34'(mz_reg); mul_b = 34'(sp_reg); end
            S_M3: begin mul_a = 34'(mx_reg); mul_b = 34'(sr_reg); end
            S_M4: begin mul_a = 34'(tmp_reg); mul_b = 34'(sp_reg); end
            S_M5: begin mul_a = 34'(my_reg); mul_b = 34'(cr_reg); end
            S_M6: begin mul_a = 34'(mz_reg); mul_b = 34'(sr_reg); end
            S_M7: begin mul_a = 34'(tmp_reg); mul_b = 34'(cp_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign in_stall = busy_reg;
    assign out_valid = ovalid_reg;
    assign pitch_deg = pitch_o_reg;
    assign roll_deg = roll_o_reg;
    assign heading_deg = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            busy_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            seeded_reg <= 1'b0;
            pitch_reg <= '0;
            roll_reg <= '0;
            pitch_o_reg <= '0;
            roll_o_reg <= '0;
            head_reg <= '0;
            alpha_reg <= 17'd64225;
            lsb_reg <= 16'd131;
            phase_reg <= '0;
            axis_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == 1'b0)
                    alpha_reg <= (cfg_data > 17'd65536) ? 17'd65536 : cfg_data;
                else
                    lsb_reg <= cfg_data[15:0];
            end
            if (state_reg == S_OUT && out_free)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (in_valid && !busy_reg) begin
                        busy_reg <= 1'b1;
                        ax_reg <= accel_x; ay_reg <= accel_y; az_reg <= accel_z;
                        gx_reg <= gyro_x; gy_reg <= gyro_y;
                        mx_reg <= mag_x; my_reg <= mag_y; mz_reg <= mag_z;
                        ms_reg <= sample_ms;
                        phase_reg <= 2'd0;
                        y_reg <= 48'(accel_x) <<< 16;
                        x_reg <= 48'(accel_z) <<< 16;
                        state_reg <= S_AT_PRE;
                    end
                end
                S_AT_PRE: begin
                    step_reg <= '0;
                    z_reg <= '0;
                    if (x_reg[CordicW-1]) begin
                        if (!y_reg[CordicW-1]) begin
                            x_reg <= y_reg; y_reg <= -x_reg; z_reg <= 48'(DEG90_Q16);
                        end else begin
                            x_reg <= -y_reg; y_reg <= x_reg; z_reg <= -48'(DEG90_Q16);
                        end
                    end
                    if (x_reg == '0 && y_reg == '0)
                        state_reg <= S_AT_END;
                    else
                        state_reg <= S_AT_IT;
                end
                S_AT_IT: begin
                    x_reg <= x_step; y_reg <= y_step; z_reg <= z_step;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == LAST_STEP) state_reg <= S_AT_END;
                end
                S_AT_END: begin
                    if (phase_reg == 2'd0) begin
                        pa_reg <= sat17(q16_out);
                        phase_reg <= 2'd1;
                        y_reg <= 48'(ay_reg) <<< 16;
                        x_reg <= 48'(az_reg) <<< 16;
                        state_reg <= S_AT_PRE;
                    end else if (phase_reg == 2'd1) begin
                        ra_reg <= sat17(q16_out);
                        if (!seeded_reg) begin
                            seeded_reg <= 1'b1;
                            pitch_reg <= pa_reg;
                            roll_reg <= sat17(q16_out);
                            axis_reg <= 1'b0;
                            z_reg <= 48'(pa_reg) <<< SH;
                            state_reg <= S_SC_PRE;
                        end else begin
                            axis_reg <= 1'b0;
                            state_reg <= S_DEN;
                        end
                    end else begin
                        tmp_reg <= z_reg[CordicW-1] ? z_reg + 48'(DEG360_Q16) : z_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_DEN: begin
                    den_reg <= 26'(mul_p);
                    state_reg <= S_NUM;
                end
                S_NUM: begin
                    nneg_reg <= mul_p[67];
                    mag_reg <= MAGW'(mul_p[67] ? -mul_p : mul_p) << ANGLE_FRAC_BITS;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    dcnt_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (dcnt_reg == LAST_DIV) begin
                        tmp_reg <= 48'(axis_reg ? roll_reg : pitch_reg)
                            + (nneg_reg ? -48'(delta_mag) : 48'(delta_mag));
                        state_reg <= S_BL1;
                    end else begin
                        if (!rem_try[32]) begin
                            rem_reg <= rem_try[31:0];
                            quo_reg <= {quo_reg[MAGW-2:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[30:0], mag_reg[MAGW-1]};
                            quo_reg <= {quo_reg[MAGW-2:0], 1'b0};
                        end
                        mag_reg <= {mag_reg[MAGW-2:0], 1'b0};
                        dcnt_reg <= dcnt_reg + 6'd1;
                    end
                end
                S_BL1: begin
                    acc_reg <= 48'(mul_p);
                    state_reg <= S_BL2;
                end
                S_BL2: begin
                    acc_reg <= acc_reg + 48'(mul_p) + 48'sd32768;
                    state_reg <= S_BL3;
                end
                S_BL3: begin
                    if (!axis_reg) begin
                        pitch_reg <= sat17(acc_reg >>> 16);
                        axis_reg <= 1'b1;
                        state_reg <= S_NUM;
                    end else begin
                        roll_reg <= sat17(acc_reg >>> 16);
                        axis_reg <= 1'b0;
                        z_reg <= 48'(pitch_reg) <<< SH;
                        state_reg <= S_SC_PRE;
                    end
                end
                S_SC_PRE: begin
                    x_reg <= 48'(CORDIC_K_Q30);
                    y_reg <= '0;
                    step_reg <= '0;
                    neg_reg <= 1'b0;
                    if (z_reg > 48'(DEG90_Q16)) begin
                        z_reg <= z_reg - 48'(DEG180_Q16); neg_reg <= 1'b1;
                    end else if (z_reg < -48'(DEG90_Q16)) begin
                        z_reg <= z_reg + 48'(DEG180_Q16); neg_reg <= 1'b1;
                    end
                    state_reg <= S_SC_IT;
                end
                S_SC_IT: begin
                    x_reg <= x_step; y_reg <= y_step; z_reg <= z_step;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == LAST_STEP) state_reg <= S_SC_END;
                end
                S_SC_END: begin
                    if (!axis_reg) begin
                        cp_reg <= neg_reg ? -17'((x_reg + 48'sd16384) >>> 15)
                                          : 17'((x_reg + 48'sd16384) >>> 15);
                        sp_reg <= neg_reg ? -17'((y_reg + 48'sd16384) >>> 15)
                                          : 17'((y_reg + 48'sd16384) >>> 15);
                        axis_reg <= 1'b1;
                        z_reg <= 48'(roll_reg) <<< SH;
                        state_reg <= S_SC_PRE;
                    end else begin
                        cr_reg <= neg_reg ? -17'((x_reg + 48'sd16384) >>> 15)
                                          : 17'((x_reg + 48'sd16384) >>> 15);
                        sr_reg <= neg_reg ? -17'((y_reg + 48'sd16384) >>> 15)
                                          : 17'((y_reg + 48'sd16384) >>> 15);
                        state_reg <= S_M1;
                    end
                end
                S_M1: begin xh_reg <= 48'(mul_p); state_reg <= S_M2; end
                S_M2: begin xh_reg <= (xh_reg + 48'(mul_p)) <<< 15; state_reg <= S_M3; end
                S_M3: begin tmp_reg <= 48'(mul_p); state_reg <= S_M4; end
                S_M4: begin yh_reg <= 48'(mul_p); state_reg <= S_M5; end
                S_M5: begin yh_reg <= yh_reg + (48'(mul_p) <<< 15); state_reg <= S_M6; end
                S_M6: begin tmp_reg <= 48'(mul_p); state_reg <= S_M7; end
                S_M7: begin yh_reg <= yh_reg - 48'(mul_p); state_reg <= S_M8; end
                S_M8: begin
                    x_reg <= xh_reg;
                    y_reg <= yh_reg;
                    phase_reg <= 2'd2;
                    state_reg <= S_AT_PRE;
                end
                S_OUT: begin
                    if (out_free) begin
                        if ($signed(tmp_reg + HALF_LSB) >>> SH >= ANG_360)
                            head_reg <= '0;
                        else
                            head_reg <= 17'((tmp_reg + HALF_LSB) >>> SH);
                        pitch_o_reg <= pitch_reg;
                        roll_o_reg <= roll_reg;
                        busy_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[tb/tb_tilt_compensated_attitude_heading_core.sv]
// Testbench for the tilt-compensated attitude and heading core: directed table plus random samples.
`timescale 1ns / 100ps

module tb_tilt_compensated_attitude_heading_core;
    import tcah_pkg::*;

    localparam int CfgBlend = 0;
    localparam int CfgGyroLsb = 1;
    localparam int NumRandom = 730;
    localparam int CycleLimit = 1500000;
    localparam int Latency = 5 * 16 + 111;

    typedef struct {
        logic signed [15:0] ax, ay, az, gx, gy, mx, my, mz;
        logic [15:0] ms;
    } sample_t;

    typedef struct {
        logic signed [16:0] pitch;
        logic signed [16:0] roll;
        logic [16:0] heading;
    } attitude_t;

    typedef struct {
        sample_t s;
        bit fixed;
        attitude_t want;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [0:0] cfg_index = 0;
    logic [16:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [15:0] accel_x = 0, accel_y = 0, accel_z = 0, gyro_x = 0, gyro_y = 0;
    logic signed [15:0] mag_x = 0, mag_y = 0, mag_z = 0;
    logic [15:0] sample_ms = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [16:0] pitch_deg, roll_deg;
    logic [16:0] heading_deg;

    longint alpha_reg, lsb_reg, pitch_st, roll_st;
    bit seeded_st;
    attitude_t attitude_q[$];
    int errors = 0, checked = 0, cycles = 0;
    bit quiet = 0, hold_off = 0;

    tilt_compensated_attitude_heading_core u_dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint asr(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint atan_tab(int i);
        return longint'(atan_q16(5'(i)));
    endfunction

    function automatic longint vec_angle(longint y, longint x);
        longint z = 0, t, xs, ys;
        if (x == 0 && y == 0) return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end
            else
            begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += atan_tab(i);
            end
            else
            begin
                x -= ys; y += xs; z -= atan_tab(i);
            end
        end
        return z;
    endfunction

    function automatic void rotate(input longint a, output longint s, output longint c);
        longint x = 652032875, y = 0, z = a, xs, ys;
        bit neg = 0;
        if (z > 90 * 65536)
        begin
            z -= 180 * 65536; neg = 1;
        end
        else if (z < -90 * 65536)
        begin
            z += 180 * 65536; neg = 1;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_tab(i);
            end
            else
            begin
                x += ys; y -= xs; z += atan_tab(i);
            end
        end
        c = asr(x + (1 << 14), 15);
        s = asr(y + (1 << 14), 15);
        if (neg)
        begin
            c = -c; s = -s;
        end
    endfunction

    function automatic longint to_q8(longint v);
        return asr(v + 128, 8);
    endfunction

    function automatic longint clamp180(longint v);
        if (v > 46080) return 46080;
        if (v < -46080) return -46080;
        return v;
    endfunction

    function automatic longint fuse(longint ang, longint acc, longint rate, longint ms);
        longint a = alpha_reg > 65536 ? 65536 : alpha_reg;
        longint den = (lsb_reg == 0 ? 1 : lsb_reg) * 1000;
        longint num = rate * ms * 256;
        longint mag = num < 0 ? -num : num;
        longint d = (mag + den / 2) / den;
        if (num < 0) d = -d;
        return clamp180(asr(a * (ang + d) + (65536 - a) * acc + 32768, 16));
    endfunction

    function automatic attitude_t predict_attitude(sample_t s);
        attitude_t r;
        longint pa, ra, sp, cp, sr, cr, xh, yh, hd;
        pa = clamp180(to_q8(vec_angle(longint'(s.ax) * 65536, longint'(s.az) * 65536)));
        ra = clamp180(to_q8(vec_angle(longint'(s.ay) * 65536, longint'(s.az) * 65536)));
        if (!seeded_st)
        begin
            pitch_st = pa; roll_st = ra; seeded_st = 1;
        end
        else
        begin
            pitch_st = fuse(pitch_st, pa, s.gx, s.ms);
            roll_st = fuse(roll_st, ra, s.gy, s.ms);
        end
        rotate(pitch_st * 256, sp, cp);
        rotate(roll_st * 256, sr, cr);
        xh = (longint'(s.mx) * cp + longint'(s.mz) * sp) * 32768;
        yh = longint'(s.mx) * sr * sp + longint'(s.my) * cr * 32768 - longint'(s.mz) * sr * cp;
        hd = vec_angle(yh, xh);
        if (hd < 0) hd += 360 * 65536;
        hd = to_q8(hd);
        if (hd >= 360 * 256 || hd < 0) hd = 0;
        r.pitch = 17'(pitch_st);
        r.roll = 17'(roll_st);
        r.heading = 17'(hd);
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s at result %0d: got %0d, want %0d", what, checked, got, want);
    endtask

    task automatic write_reg(int idx, longint val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= 1'(idx);
        cfg_data <= 17'(val);
        @(negedge clk);
        cfg_we <= 0;
        if (idx == CfgBlend) alpha_reg = val & 17'h1FFFF;
        else lsb_reg = val & 16'hFFFF;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (attitude_q.size() != 0) @(negedge clk);
        repeat (Latency) @(negedge clk);
    endtask

    task automatic send(sample_t s, bit fixed, attitude_t want);
        attitude_t p;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid <= 1;
        accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
        gyro_x <= s.gx; gyro_y <= s.gy;
        mag_x <= s.mx; mag_y <= s.my; mag_z <= s.mz;
        sample_ms <= s.ms;
        do @(posedge clk); while (in_stall);
        p = predict_attitude(s);
        attitude_q.push_back(fixed ? want : p);
        @(negedge clk);
    endtask

    function automatic sample_t rand_sample(bit wild);
        sample_t s;
        if (wild)
        begin
            s.ax = $urandom; s.ay = $urandom; s.az = $urandom;
            s.gx = $urandom; s.gy = $urandom;
            s.mx = $urandom; s.my = $urandom; s.mz = $urandom;
            s.ms = $urandom;
        end
        else
        begin
            s.ax = $urandom_range(0, 8000) - 4000;
            s.ay = $urandom_range(0, 8000) - 4000;
            s.az = $urandom_range(10000, 20000) * ($urandom_range(0, 7) == 0 ? -1 : 1);
            s.gx = $urandom_range(0, 4000) - 2000;
            s.gy = $urandom_range(0, 4000) - 2000;
            s.mx = $urandom_range(0, 2000) - 1000;
            s.my = $urandom_range(0, 2000) - 1000;
            s.mz = $urandom_range(0, 2000) - 1000;
            s.ms = $urandom_range(1, 50);
        end
        return s;
    endfunction

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (attitude_q.size() == 0)
                report("unexpected", 0, 0);
            else
            begin
                attitude_t w;
                w = attitude_q.pop_front();
                if (pitch_deg !== w.pitch) report("pitch", pitch_deg, w.pitch);
                if (roll_deg !== w.roll) report("roll", roll_deg, w.roll);
                if (heading_deg !== w.heading) report("heading", heading_deg, w.heading);
            end
            checked++;
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off) out_stall <= 1;
            else if (!quiet && !out_stall && $urandom_range(0, 5) == 0) out_stall <= 1;
            else if (out_stall && (quiet || $urandom_range(0, 3) == 0)) out_stall <= 0;
        end
    end

    initial
    begin
        row_t rows[$];
        sample_t s;
        attitude_t w;
        alpha_reg = 64225; lsb_reg = 131;
        pitch_st = 0; roll_st = 0; seeded_st = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // seed from a level board: zero angles, heading north
        s = '{ax: 0, ay: 0, az: 16384, gx: 0, gy: 0, mx: 1000, my: 0, mz: 0, ms: 10};
        w = '{pitch: 0, roll: 0, heading: 0};
        rows.push_back('{s: s, fixed: 1, want: w});
        s = '{ax: 0, ay: 0, az: 0, gx: 0, gy: 0, mx: 0, my: 0, mz: 0, ms: 0};
        rows.push_back('{s: s, fixed: 1, want: w});
        s = '{ax: 0, ay: 0, az: -16384, gx: 0, gy: 0, mx: 0, my: 0, mz: 0, ms: 0};
        rows.push_back('{s: s, fixed: 0, want: w});
        s = '{ax: -1, ay: 0, az: -32768, gx: 32767, gy: -32768, mx: 32767,
              my: -32768, mz: 32767, ms: 65535};
        rows.push_back('{s: s, fixed: 0, want: w});
        s = '{ax: 32767, ay: -32768, az: 0, gx: -32768, gy: 32767, mx: -32768,
              my: 32767, mz: -32768, ms: 65535};
        rows.push_back('{s: s, fixed: 0, want: w});
        s = '{ax: -32768, ay: 32767, az: 32767, gx: 100, gy: -100, mx: 0,
              my: 500, mz: 0, ms: 1};
        rows.push_back('{s: s, fixed: 0, want: w});
        s = '{ax: 0, ay: 0, az: 16384, gx: 0, gy: 0, mx: 1000, my: -1, mz: 0, ms: 0};
        rows.push_back('{s: s, fixed: 0, want: w});
        for (int i = 0; i < 8; i++)
            rows.push_back('{s: rand_sample(i[0]), fixed: 0, want: w});
        foreach (rows[i]) send(rows[i].s, rows[i].fixed, rows[i].want);
        drain();

        write_reg(CfgBlend, 65536);
        write_reg(CfgGyroLsb, 0);
        for (int i = 0; i < 6; i++) send(rand_sample(i[0]), 0, w);
        drain();
        write_reg(CfgBlend, 0);
        write_reg(CfgGyroLsb, 65535);
        for (int i = 0; i < 6; i++) send(rand_sample(i[0]), 0, w);
        drain();
        write_reg(CfgBlend, 131071);
        write_reg(CfgGyroLsb, 1);
        for (int i = 0; i < 6; i++) send(rand_sample(i[0]), 0, w);
        drain();

        for (int i = 0; i < NumRandom; i++)
        begin
            if (i % 150 == 149)
            begin
                drain();
                write_reg(CfgBlend, $urandom_range(0, 131071));
                write_reg(CfgGyroLsb, $urandom_range(0, 65535));
            end
            if (i == 300)
                fork
                    begin
                        hold_off = 1;
                        repeat (400) @(negedge clk);
                        hold_off = 0;
                    end
                join_none
            if (i > NumRandom - 80) quiet = 1;
            send(rand_sample($urandom_range(0, 4) == 0), 0, w);
        end
        drain();

        $display("checked %0d results over %0d cycles: reset defaults, three edge settings,",
                 checked, cycles);
        $display("random settings, extreme samples and a long output hold-off");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
